// ===== hw/rtl/rgb_led_strip_serializer_core_macros.svh =====
// Assertion helpers for the RGB LED strip serializer.
`ifndef RGB_LED_STRIP_SERIALIZER_CORE_MACROS_SVH
`define RGB_LED_STRIP_SERIALIZER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serializer assertion failed");

// Next-cycle implication.
`define RLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serializer assertion failed");

`else

`define RLS_ASSERT_NOW(label, clk, rst, ante, cons)
`define RLS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/rgbled_pkg.sv =====
package rgbled_pkg;

   localparam int MAX_PIXELS_DEF = 256;
   localparam int BITS_PER_PIXEL = 24;

   localparam logic [1:0] OP_SET_COLOR = 2'd0;
   localparam logic [1:0] OP_CLEAR     = 2'd1;
   localparam logic [1:0] OP_SHOW      = 2'd2;
   localparam logic [1:0] OP_TICK      = 2'd3;

   localparam logic [2:0] CSR_NUM_PIXELS      = 3'd0;
   localparam logic [2:0] CSR_ONE_HIGH_TICKS  = 3'd1;
   localparam logic [2:0] CSR_ZERO_HIGH_TICKS = 3'd2;
   localparam logic [2:0] CSR_BIT_TICKS       = 3'd3;
   localparam logic [2:0] CSR_LATCH_TICKS     = 3'd4;

   localparam logic [8:0]  NUM_PIXELS_RST      = 9'd8;
   localparam logic [15:0] ONE_HIGH_TICKS_RST  = 16'd12;
   localparam logic [15:0] ZERO_HIGH_TICKS_RST = 16'd4;
   localparam logic [15:0] BIT_TICKS_RST       = 16'd16;
   localparam logic [15:0] LATCH_TICKS_RST     = 16'd800;

   typedef logic [23:0] color_type;

   // RRGGBB as stored -> GGRRBB as sent
   function automatic color_type grb_of(input color_type c);
      return {c[15:8], c[23:16], c[7:0]};
   endfunction

endpackage

// ===== hw/rtl/rgb_led_strip_serializer_core.sv =====
// Channel   Ports                                      Direction
// request   req_valid/req_ready, op, index, colour     in
// response  rsp_valid/rsp_ready, line level, busy      out
// csr       csr_wr_en, csr_index, csr_wdata            in
//
// One request per cycle: each request is decoded and the line state advanced
// in the cycle it is taken; its response sits in an output register.
// req_ready drops only while a response waits and rsp_ready is low.
// The colour store is a RAM with one write and one read port, read one pixel
// ahead of the shifter; per-entry valid flags give the zero reset and an all-entry clear.
// Synchronous active-high reset; no clearing pass is needed.

`include "rgb_led_strip_serializer_core_macros.svh"

module rgb_led_strip_serializer_core #(
   parameter int MAX_PIXELS = rgbled_pkg::MAX_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_pixel_index,
   input  logic [23:0] req_color,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_line_level,
   output logic        rsp_busy_res,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import rgbled_pkg::*;

   localparam int AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int CMP_W  = (CNT_W > 9) ? CNT_W : 9;

   // configuration
   logic [8:0]  num_pixels_ff;
   logic [15:0] one_high_ff;
   logic [15:0] zero_high_ff;
   logic [15:0] bit_ticks_ff;
   logic [15:0] latch_ticks_ff;

   // line state
   logic             sending_ff,   sending_in;
   logic             latch_ff,     latch_in;
   logic [CNT_W-1:0] pc_ff,        pc_in;
   logic [4:0]       bc_ff,        bc_in;
   logic [15:0]      tc_ff,        tc_in;
   logic [23:0]      shift_ff,     shift_in;

   // colour store
   color_type             mem [MAX_PIXELS];
   logic [MAX_PIXELS-1:0] valid_ff;
   color_type             next_color_ff;

   // response register
   logic rsp_valid_ff;
   logic rsp_level_ff;
   logic rsp_busy_ff;

   logic           accept;
   logic           idle_cmd;
   logic           wr_en;
   logic           clr_en;
   logic [CMP_W-1:0] eff_pixels;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W:0]   pc_plus;
   logic [CMP_W:0]   pc_in_plus;
   logic [4:0]       bc_plus;
   logic [16:0]      tc_plus;
   logic [15:0]      period;
   logic [15:0]      high_sel;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic             level_in;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_level_ff;
   assign rsp_busy_res   = rsp_busy_ff;

   always_comb begin
      if (CMP_W'(num_pixels_ff) > CMP_W'(MAX_PIXELS)) begin
         eff_pixels = CMP_W'(MAX_PIXELS);
      end else begin
         eff_pixels = CMP_W'(num_pixels_ff);
      end
   end

   assign idle_cmd = accept && !sending_ff;
   assign idx_ext  = CMP_W'(req_pixel_index);
   assign wr_addr  = idx_ext[AW-1:0];
   assign wr_en    = idle_cmd && (req_op == OP_SET_COLOR) && (idx_ext < eff_pixels);
   assign clr_en   = idle_cmd && (req_op == OP_CLEAR);

   assign pc_plus  = (CMP_W + 1)'(pc_ff) + (CMP_W + 1)'(1);
   assign bc_plus  = bc_ff + 5'd1;
   assign tc_plus  = {1'b0, tc_ff} + 17'd1;
   assign period   = (bit_ticks_ff == 16'd0) ? 16'd1 : bit_ticks_ff;

   always_comb begin
      sending_in = sending_ff;
      latch_in   = latch_ff;
      pc_in      = pc_ff;
      bc_in      = bc_ff;
      tc_in      = tc_ff;
      shift_in   = shift_ff;
      if (accept && (req_op == OP_TICK) && sending_ff) begin
         if (latch_ff) begin
            if (tc_plus >= {1'b0, latch_ticks_ff}) begin
               sending_in = 1'b0;
               latch_in   = 1'b0;
               tc_in      = 16'd0;
            end else begin
               tc_in = tc_plus[15:0];
            end
         end else if (tc_plus < {1'b0, period}) begin
            tc_in = tc_plus[15:0];
         end else begin
            tc_in    = 16'd0;
            shift_in = {shift_ff[22:0], 1'b0};
            if (bc_plus < 5'(BITS_PER_PIXEL)) begin
               bc_in = bc_plus;
            end else begin
               bc_in = 5'd0;
               if (pc_plus < {1'b0, eff_pixels}) begin
                  pc_in    = pc_plus[CNT_W-1:0];
                  shift_in = grb_of(next_color_ff);
               end else begin
                  pc_in      = '0;
                  shift_in   = 24'd0;
                  sending_in = (latch_ticks_ff != 16'd0);
                  latch_in   = (latch_ticks_ff != 16'd0);
               end
            end
         end
      end else if (idle_cmd && (req_op == OP_SHOW)) begin
         pc_in = '0;
         bc_in = 5'd0;
         tc_in = 16'd0;
         if (eff_pixels != '0) begin
            shift_in   = grb_of(next_color_ff);
            sending_in = 1'b1;
            latch_in   = 1'b0;
         end else begin
            shift_in   = 24'd0;
            sending_in = (latch_ticks_ff != 16'd0);
            latch_in   = (latch_ticks_ff != 16'd0);
         end
      end
   end

   assign high_sel = shift_in[23] ? one_high_ff : zero_high_ff;
   assign level_in = sending_in && !latch_in && (tc_in < high_sel);

   // prefetch the pixel after the one in the shifter; entry 0 while idle or latching
   assign pc_in_plus = (CMP_W + 1)'(pc_in) + (CMP_W + 1)'(1);
   assign rd_addr    = (sending_in && !latch_in) ? pc_in_plus[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_color;
      end
      if (reset || clr_en) begin
         next_color_ff <= '0;
      end else if (wr_en && (wr_addr == rd_addr)) begin
         next_color_ff <= req_color;
      end else if (valid_ff[rd_addr]) begin
         next_color_ff <= mem[rd_addr];
      end else begin
         next_color_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clr_en) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_pixels_ff  <= NUM_PIXELS_RST;
         one_high_ff    <= ONE_HIGH_TICKS_RST;
         zero_high_ff   <= ZERO_HIGH_TICKS_RST;
         bit_ticks_ff   <= BIT_TICKS_RST;
         latch_ticks_ff <= LATCH_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_PIXELS:      num_pixels_ff  <= csr_wdata[8:0];
            CSR_ONE_HIGH_TICKS:  one_high_ff    <= csr_wdata;
            CSR_ZERO_HIGH_TICKS: zero_high_ff   <= csr_wdata;
            CSR_BIT_TICKS:       bit_ticks_ff   <= csr_wdata;
            CSR_LATCH_TICKS:     latch_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         pc_ff        <= '0;
         bc_ff        <= 5'd0;
         tc_ff        <= 16'd0;
         shift_ff     <= 24'd0;
         rsp_valid_ff <= 1'b0;
         rsp_level_ff <= 1'b0;
         rsp_busy_ff  <= 1'b0;
      end else begin
         sending_ff <= sending_in;
         latch_ff   <= latch_in;
         pc_ff      <= pc_in;
         bc_ff      <= bc_in;
         tc_ff      <= tc_in;
         shift_ff   <= shift_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            rsp_level_ff <= level_in;
            rsp_busy_ff  <= sending_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `RLS_ASSERT_NOW(a_idle_line_low, clock, reset, rsp_valid_ff && !rsp_busy_ff, !rsp_level_ff)
   `RLS_ASSERT_NOW(a_latch_in_frame, clock, reset, latch_ff, sending_ff)
   `RLS_ASSERT_NOW(a_bit_count_range, clock, reset, sending_ff, bc_ff < 5'(BITS_PER_PIXEL))
   `RLS_ASSERT_NEXT(a_show_starts, clock, reset, idle_cmd && (req_op == OP_SHOW) && (eff_pixels != '0), sending_ff && !latch_ff)

endmodule

// ===== dv/rgb_led_strip_serializer_core_tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
   logic level;
   logic busy;
} line_sample_type;

class strip_scoreboard;
   rgbled_pkg::color_type colours [rgbled_pkg::MAX_PIXELS_DEF];
   bit                    sending;
   bit                    latching;
   int unsigned           pixel_idx;
   int unsigned           bit_idx;
   int unsigned           tick_idx;
   logic [23:0]           shifter;

   logic [8:0]            num_pixels;
   logic [15:0]           one_high;
   logic [15:0]           zero_high;
   logic [15:0]           period;
   logic [15:0]           latch_len;

   line_sample_type       expected_samples [$];
   int unsigned           mismatches;
   int unsigned           checked;
   int unsigned           frames;

   function new();
      foreach (colours[i]) colours[i] = '0;
      sending    = 1'b0;
      latching   = 1'b0;
      pixel_idx  = 0;
      bit_idx    = 0;
      tick_idx   = 0;
      shifter    = '0;
      num_pixels = rgbled_pkg::NUM_PIXELS_RST;
      one_high   = rgbled_pkg::ONE_HIGH_TICKS_RST;
      zero_high  = rgbled_pkg::ZERO_HIGH_TICKS_RST;
      period     = rgbled_pkg::BIT_TICKS_RST;
      latch_len  = rgbled_pkg::LATCH_TICKS_RST;
      mismatches = 0;
      checked    = 0;
      frames     = 0;
   endfunction

   function int unsigned active_pixels();
      return (num_pixels > rgbled_pkg::MAX_PIXELS_DEF) ? rgbled_pkg::MAX_PIXELS_DEF : num_pixels;
   endfunction

   // stored RRGGBB goes out as GGRRBB
   function logic [23:0] send_order(int unsigned i);
      rgbled_pkg::color_type c;
      c = colours[i];
      return {c[15:8], c[23:16], c[7:0]};
   endfunction

   function logic line_now();
      logic [15:0] high_len;
      if (!sending || latching) return 1'b0;
      high_len = shifter[23] ? one_high : zero_high;
      return tick_idx < high_len;
   endfunction

   function void start_latch();
      tick_idx = 0;
      sending  = (latch_len != 0);
      latching = (latch_len != 0);
   endfunction

   function void step_time();
      int unsigned span;
      span = (period == 0) ? 1 : period;
      if (!sending) return;
      if (latching) begin
         tick_idx++;
         if (tick_idx >= latch_len) begin
            sending  = 1'b0;
            latching = 1'b0;
            tick_idx = 0;
         end
         return;
      end
      if (tick_idx + 1 < span) begin
         tick_idx++;
         return;
      end
      tick_idx = 0;
      shifter  = shifter << 1;
      bit_idx++;
      if (bit_idx < rgbled_pkg::BITS_PER_PIXEL) return;
      bit_idx = 0;
      pixel_idx++;
      if (pixel_idx < active_pixels()) begin
         shifter = send_order(pixel_idx);
      end else begin
         pixel_idx = 0;
         shifter   = '0;
         start_latch();
      end
   endfunction

   function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
         rgbled_pkg::CSR_NUM_PIXELS:      num_pixels = data[8:0];
         rgbled_pkg::CSR_ONE_HIGH_TICKS:  one_high   = data;
         rgbled_pkg::CSR_ZERO_HIGH_TICKS: zero_high  = data;
         rgbled_pkg::CSR_BIT_TICKS:       period     = data;
         rgbled_pkg::CSR_LATCH_TICKS:     latch_len  = data;
         default: ;
      endcase
   endfunction

   function void note_request(logic [1:0] op, logic [7:0] idx, logic [23:0] col);
      line_sample_type s;
      if (op == rgbled_pkg::OP_TICK) begin
         step_time();
      end else if (!sending) begin
         case (op)
            rgbled_pkg::OP_SET_COLOR: begin
               if (idx < active_pixels()) colours[idx] = col;
            end
            rgbled_pkg::OP_CLEAR: begin
               foreach (colours[i]) colours[i] = '0;
            end
            rgbled_pkg::OP_SHOW: begin
               pixel_idx = 0;
               bit_idx   = 0;
               tick_idx  = 0;
               frames++;
               if (active_pixels() > 0) begin
                  shifter  = send_order(0);
                  sending  = 1'b1;
                  latching = 1'b0;
               end else begin
                  shifter = '0;
                  start_latch();
               end
            end
            default: ;
         endcase
      end
      s.level = line_now();
      s.busy  = sending;
      expected_samples.push_back(s);
   endfunction

   function void check_response(logic level, logic busy);
      line_sample_type want;
      if (expected_samples.size() == 0) begin
         $error("response with no request outstanding: line_level %0b busy_res %0b",
                level, busy);
         mismatches++;
         return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (level !== want.level) begin
         $error("line_level: expected %0b, got %0b", want.level, level);
         mismatches++;
      end
      if (busy !== want.busy) begin
         $error("busy_res: expected %0b, got %0b", want.busy, busy);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return expected_samples.size();
   endfunction
endclass

module rgb_led_strip_serializer_core_tb;
   import rgbled_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ITEM_TARGET    = 550;

   // indexes with no register behind them
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op          = OP_TICK;
   logic [7:0]  req_pixel_index = '0;
   logic [23:0] req_color       = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic        csr_wr_en       = 1'b0;
   logic [2:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   strip_scoreboard sb = new();
   bit          calm = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned reg_writes = 0;
   int unsigned idle_cycles = 0;

   rgb_led_strip_serializer_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pixel_index (req_pixel_index),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_level  (rsp_line_level),
      .rsp_busy_res    (rsp_busy_res),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_line_level, rsp_busy_res);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_cycles++;
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] idx,
                               input logic [23:0] col);
      bit taken;
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_pixel_index <= idx;
      req_color       <= col;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      sb.note_request(op, idx, col);
      requests_sent++;
   endtask

   task automatic step_line();
      send_request(OP_TICK, 8'($urandom_range(255)), 24'($urandom()));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // leaves csr_wr_en high; callers lower it after the last write
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_register(idx, data);
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic write_single(input logic [2:0] idx, input logic [15:0] data);
      wait_drained();
      write_reg(idx, data);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_timing(input logic [15:0] pixels, input logic [15:0] one_hi,
                                 input logic [15:0] zero_hi, input logic [15:0] bit_len,
                                 input logic [15:0] latch);
      wait_drained();
      write_reg(CSR_NUM_PIXELS, pixels);
      write_reg(CSR_ONE_HIGH_TICKS, one_hi);
      write_reg(CSR_ZERO_HIGH_TICKS, zero_hi);
      write_reg(CSR_BIT_TICKS, bit_len);
      write_reg(CSR_LATCH_TICKS, latch);
      csr_wr_en <= 1'b0;
   endtask

   // tick until frame and latch gap are over; noise requests are ignored while busy
   task automatic run_out(input bit noisy);
      while (sb.sending) begin
         if (noisy && $urandom_range(9) == 0)
            send_request(2'($urandom_range(3)), 8'($urandom_range(255)), 24'($urandom()));
         else
            step_line();
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned pixels;
      int unsigned bit_len;
      int unsigned r;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, idle behaviour and store writes
      step_line();
      send_request(OP_SET_COLOR, 8'd0, 24'hFFFFFF);
      send_request(OP_SET_COLOR, 8'd7, 24'h5AA53C);
      send_request(OP_SET_COLOR, 8'd8, 24'h123456);
      send_request(OP_SET_COLOR, 8'd255, 24'hFFFFFF);
      send_request(OP_CLEAR, 8'd0, 24'h000000);
      send_request(OP_SET_COLOR, 8'd0, 24'h800001);
      send_request(OP_SET_COLOR, 8'd1, 24'h7FFFFE);

      // two pixel frame, commands while busy must be dropped; no idling here
      calm = 1'b1;
      program_timing(16'd2, 16'd2, 16'd1, 16'd3, 16'd2);
      send_request(OP_SHOW, 8'd0, 24'h0);
      send_request(OP_SET_COLOR, 8'd1, 24'h000000);
      send_request(OP_CLEAR, 8'd0, 24'h0);
      send_request(OP_SHOW, 8'd0, 24'h0);
      run_out(1'b0);
      calm = 1'b0;

      // empty frame: latch only, then nothing at all
      program_timing(16'd0, 16'd2, 16'd1, 16'd3, 16'd3);
      send_request(OP_SHOW, 8'd0, 24'h0);
      run_out(1'b0);
      write_single(CSR_LATCH_TICKS, 16'd0);
      send_request(OP_SHOW, 8'd0, 24'h0);
      step_line();

      // zero latch, zero and unit periods, zero and full high times
      program_timing(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
      send_request(OP_SHOW, 8'd0, 24'h0);
      run_out(1'b0);
      program_timing(16'd1, 16'd0, 16'd0, 16'd1, 16'd1);
      send_request(OP_SHOW, 8'd0, 24'h0);
      run_out(1'b0);
      program_timing(16'd2, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1);
      send_request(OP_SHOW, 8'd0, 24'h0);
      run_out(1'b0);

      // full chain addressable, count above the store size clamps
      program_timing(16'd256, 16'd12, 16'd4, 16'd2, 16'd10);
      send_request(OP_SET_COLOR, 8'd255, 24'($urandom()));
      send_request(OP_SET_COLOR, 8'd200, 24'($urandom()));
      program_timing(16'h01FF, 16'd40000, 16'd1, 16'hFFFF, 16'hFFFF);
      send_request(OP_SET_COLOR, 8'd254, 24'($urandom()));
      send_request(OP_SHOW, 8'd0, 24'h0);
      repeat (6) step_line();

      // registers changed mid-frame
      write_single(CSR_BIT_TICKS, 16'd2);
      repeat (4) step_line();
      write_single(CSR_NUM_PIXELS, 16'hFE01);
      while (!sb.latching) step_line();
      repeat (5) step_line();
      write_single(CSR_LATCH_TICKS, 16'd1);
      wait_drained();
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h0000);
      csr_wr_en <= 1'b0;
      run_out(1'b0);

      phase = 0;
      while (requests_sent < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 10) pixels = 0;
         else if (r < 80) pixels = $urandom_range(2, 1);
         else pixels = $urandom_range(6, 3);
         bit_len = $urandom_range(4);
         program_timing(16'(pixels), 16'($urandom_range(bit_len + 1)),
                        16'($urandom_range(bit_len + 1)), 16'(bit_len),
                        16'(($urandom_range(99) < 25) ? 0 : $urandom_range(12, 1)));

         repeat ($urandom_range(5, 1)) begin
            r = $urandom_range(99);
            if (r < 8)
               send_request(OP_CLEAR, 8'($urandom_range(255)), 24'($urandom()));
            else if (r < 18)
               step_line();
            else if (r < 30 || pixels == 0)
               send_request(OP_SET_COLOR, 8'($urandom_range(255)), 24'($urandom()));
            else
               send_request(OP_SET_COLOR, 8'($urandom_range(pixels - 1)), 24'($urandom()));
         end

         if ($urandom_range(9) != 0) begin
            send_request(OP_SHOW, 8'($urandom_range(255)), 24'($urandom()));
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(20, 1)) step_line();
               write_single(3'($urandom_range(CSR_LATCH_TICKS)), 16'($urandom_range(5)));
            end
         end
         run_out(1'b1);
         phase++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.mismatches++;
      end
      $display("%0d requests sent, %0d responses checked, %0d shows, %0d register writes",
               requests_sent, sb.checked, sb.frames, reg_writes);
      $display("%0d random phases with mixed pixel counts, periods, high times and latch gaps",
               phase);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
